>>> rtl/ests_pkg.sv
package ests_pkg;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SETTLE  = 3'd1,
        PH_STARTER = 3'd2,
        PH_UP      = 3'd3,
        PH_DOWN    = 3'd4,
        PH_MANUAL  = 3'd5
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_PMUL,
        S_PDIV,
        S_RDIV,
        S_RPOW,
        S_RLERP,
        S_DONE
    } seq_state_t;

    localparam logic [2:0] CFG_IDLE_ANGLE  = 3'd0;
    localparam logic [2:0] CFG_MAX_ANGLE   = 3'd1;
    localparam logic [2:0] CFG_STARTER_MS  = 3'd2;
    localparam logic [2:0] CFG_RAMP_UP_MS  = 3'd3;
    localparam logic [2:0] CFG_RAMP_DN_MS  = 3'd4;
    localparam logic [2:0] CFG_RAMP_EXP    = 3'd5;

    localparam logic [6:0]  PCT_KNEE = 7'd5;
    localparam logic [6:0]  PCT_FULL = 7'd100;
    localparam logic [15:0] PCT_DEN  = 16'd95;
    localparam logic [15:0] PCT_RND  = 16'd94;

endpackage

>>> rtl/ests_mul.sv
module ests_mul import ests_pkg::*; #(
    parameter int AW = 16,
    parameter int BW = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic             done,
    output logic [AW+BW-1:0] prod
);

    localparam int CW = $clog2(BW);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [AW-1:0]    a_reg, a_next;
    logic [AW+BW-1:0] p_reg, p_next;
    logic [AW:0]      sum;

    // shift-add: one multiplier bit per cycle, lsb first
    always_comb begin
        sum       = {1'b0, p_reg[AW+BW-1:BW]} + (p_reg[0] ? {1'b0, a_reg} : '0);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        p_next    = p_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = a;
            p_next    = {{AW{1'b0}}, b};
        end else if (busy_reg) begin
            p_next   = {sum, p_reg[BW-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(BW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        a_reg <= a_next;
        p_reg <= p_next;
    end

    assign done = done_reg;
    assign prod = p_reg;

endmodule

>>> rtl/ests_div.sv
module ests_div import ests_pkg::*; #(
    parameter int QW = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [QW+15:0]  num,
    input  logic [15:0]     den,
    output logic            done,
    output logic [QW-1:0]   quot
);

    localparam int CW = $clog2(QW);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [15:0]     d_reg, d_next;
    logic [15:0]     rem_reg, rem_next;
    logic [QW-1:0]   nq_reg, nq_next;
    logic [16:0]     trial;
    logic            fits;

    // restoring division, one quotient bit per cycle; upper num bits stay below den
    always_comb begin
        trial     = {rem_reg, nq_reg[QW-1]};
        fits      = trial >= {1'b0, d_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        d_next    = d_reg;
        rem_next  = rem_reg;
        nq_next   = nq_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            d_next    = den;
            rem_next  = num[QW+15:QW];
            nq_next   = num[QW-1:0];
        end else if (busy_reg) begin
            rem_next = fits ? 16'(trial - {1'b0, d_reg}) : trial[15:0];
            nq_next  = {nq_reg[QW-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(QW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        d_reg   <= d_next;
        rem_reg <= rem_next;
        nq_reg  <= nq_next;
    end

    assign done = done_reg;
    assign quot = nq_reg;

endmodule

>>> rtl/engine_start_throttle_sequencer.sv
// Channel  | Dir | Handshake                | Payload
// s_*      | in  | s_tvalid / s_tready      | s_tdata: one ms tick (buttons, mode, percent)
// m_*      | out | m_tvalid / m_tready      | m_tdata: servo command, relay, phase, running
// cfg_*    | in  | cfg_valid / cfg_ready    | cfg_addr register index, cfg_data value
//
// One tick at a time. Ticks with no arithmetic go straight to the output; a percent map
// runs a multiply then a divide; a ramp point runs a divide then one or more multiplies,
// all on the shared bit-serial multiplier and divider of width MW = max(FRAC_BITS, 8).
// A new tick is taken while the previous result waits in the output register.
// aresetn is synchronous, active low; it restores the register defaults and idles.
// cfg_ready is always high.
module engine_start_throttle_sequencer import ests_pkg::*; #(
    parameter int SETTLE_MS = 300,
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] start_pressed, [1] stop_pressed, [2] stop_cooldown, [3] manual_mode,
    // [10:4] target_percent
    input  logic [15:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] servo_write, [8:1] servo_angle, [9] starter relay energized, [12:10] phase_code,
    // [13] in_progress
    output logic [15:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_data
);

    localparam int F  = FRAC_BITS;
    localparam int MW = (FRAC_BITS > 8) ? FRAC_BITS : 8;
    localparam int PW = F + MW;
    localparam int NW = 16 + MW;

    seq_state_t  state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic        running_reg, running_next;
    logic        relay_reg, relay_next;
    logic [7:0]  from_reg, from_next;
    logic [7:0]  to_reg, to_next;

    logic [7:0]  idle_ang_reg, max_ang_reg;
    logic [15:0] starter_ms_reg, up_ms_reg, down_ms_reg;
    logic [2:0]  exp_reg;

    logic        in_start_reg, in_stop_reg, in_manual_reg;
    logic [6:0]  in_pct_reg;
    logic        in_start_next, in_stop_next, in_manual_next;
    logic [6:0]  in_pct_next;

    logic        wr_reg, wr_next;
    logic [7:0]  ang_reg, ang_next;
    logic        to_dest_reg, to_dest_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [F-1:0] q_reg, q_next;

    logic        mul_go_reg, mul_go_next;
    logic [F-1:0] mul_a_reg, mul_a_next;
    logic [MW-1:0] mul_b_reg, mul_b_next;
    logic        div_go_reg, div_go_next;
    logic [NW-1:0] div_n_reg, div_n_next;
    logic [15:0] div_d_reg, div_d_next;

    logic        mul_done, div_done;
    logic [PW-1:0] mul_prod;
    logic [MW-1:0] div_quot;

    logic        mtv_reg;
    logic [15:0] mtd_reg;
    logic        out_free;
    logic        load_out;

    logic        s_acc;
    logic        stop_w;
    logic [15:0] el_inc;
    logic [6:0]  p_sat;
    logic        need_pct;
    logic        pct_down;
    logic [7:0]  pct_diff;
    logic        ramp_down;
    logic [7:0]  ramp_diff;
    logic [1:0]  exp_m1;
    logic [7:0]  pct_val;
    logic [F-1:0] s_new;
    logic [PW:0] lerp_sum;
    logic [7:0]  lerp_delta;

    ests_mul #(.AW(F), .BW(MW)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_go_reg),
        .a(mul_a_reg), .b(mul_b_reg), .done(mul_done), .prod(mul_prod)
    );

    ests_div #(.QW(MW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_go_reg),
        .num(div_n_reg), .den(div_d_reg), .done(div_done), .quot(div_quot)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !mtv_reg || m_tready;
    assign load_out  = (state_reg == S_DONE) && out_free;

    assign stop_w    = in_stop_reg;
    assign el_inc    = (phase_reg != PH_IDLE && phase_reg != PH_MANUAL &&
                        elapsed_reg != 16'hFFFF) ? elapsed_reg + 16'd1 : elapsed_reg;
    assign p_sat     = (in_pct_reg > PCT_FULL) ? PCT_FULL : in_pct_reg;
    assign need_pct  = p_sat > PCT_KNEE;
    assign pct_down  = max_ang_reg < idle_ang_reg;
    assign pct_diff  = pct_down ? idle_ang_reg - max_ang_reg : max_ang_reg - idle_ang_reg;
    assign ramp_down = to_reg < from_reg;
    assign ramp_diff = ramp_down ? from_reg - to_reg : to_reg - from_reg;
    assign exp_m1    = (exp_reg == 3'd0) ? 2'd0 :
                       (exp_reg > 3'd4) ? 2'd3 : 2'(exp_reg - 3'd1);
    assign pct_val   = pct_down ? idle_ang_reg - div_quot[7:0] : idle_ang_reg + div_quot[7:0];
    assign s_new     = mul_prod[2*F-1:F];
    assign lerp_sum  = {1'b0, mul_prod} + (ramp_down ? (PW+1)'((1 << F) - 1) : '0);
    assign lerp_delta = lerp_sum[F+7:F];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_acc) state_next = S_DECIDE;
            S_DECIDE: begin
                state_next = S_DONE;
                if (!stop_w) begin
                    case (phase_reg)
                        PH_UP:
                            if (el_inc >= up_ms_reg) state_next = need_pct ? S_PMUL : S_DONE;
                            else state_next = S_RDIV;
                        PH_DOWN:
                            if (el_inc < down_ms_reg) state_next = S_RDIV;
                        PH_MANUAL:
                            if (need_pct) state_next = S_PMUL;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_PMUL:  if (mul_done) state_next = S_PDIV;
            S_PDIV:  if (div_done) state_next = S_DONE;
            S_RDIV:  if (div_done) state_next = (cnt_reg == 2'd0) ? S_RLERP : S_RPOW;
            S_RPOW:  if (mul_done) state_next = (cnt_reg == 2'd1) ? S_RLERP : S_RPOW;
            S_RLERP: if (mul_done) state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and sequence state
    always_comb begin
        phase_next     = phase_reg;
        elapsed_next   = elapsed_reg;
        running_next   = running_reg;
        relay_next     = relay_reg;
        from_next      = from_reg;
        to_next        = to_reg;
        in_start_next  = in_start_reg;
        in_stop_next   = in_stop_reg;
        in_manual_next = in_manual_reg;
        in_pct_next    = in_pct_reg;
        wr_next        = wr_reg;
        ang_next       = ang_reg;
        to_dest_next   = to_dest_reg;
        cnt_next       = cnt_reg;
        q_next         = q_reg;
        mul_go_next    = 1'b0;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        div_go_next    = 1'b0;
        div_n_next     = div_n_reg;
        div_d_next     = div_d_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    in_start_next  = s_tdata[0];
                    in_stop_next   = s_tdata[1] | s_tdata[2];
                    in_manual_next = s_tdata[3];
                    in_pct_next    = s_tdata[10:4];
                end
            end
            S_DECIDE: begin
                wr_next      = 1'b0;
                ang_next     = 8'd0;
                elapsed_next = el_inc;
                to_dest_next = 1'b0;
                // hold the percent operands for the map; knee and below resolve at once
                mul_a_next   = F'(pct_diff);
                mul_b_next   = MW'(p_sat - PCT_KNEE);
                if (stop_w) begin
                    running_next = 1'b0;
                    phase_next   = PH_IDLE;
                    relay_next   = 1'b0;
                    wr_next      = 1'b1;
                end else begin
                    case (phase_reg)
                        PH_IDLE: begin
                            if (in_start_reg && !running_reg) begin
                                wr_next      = 1'b1;
                                ang_next     = idle_ang_reg;
                                elapsed_next = 16'd0;
                                running_next = 1'b1;
                                if (in_manual_reg) begin
                                    relay_next = 1'b1;
                                    phase_next = PH_STARTER;
                                end else begin
                                    phase_next = PH_SETTLE;
                                end
                            end
                        end
                        PH_SETTLE: begin
                            if (el_inc >= 16'(SETTLE_MS)) begin
                                relay_next   = 1'b1;
                                elapsed_next = 16'd0;
                                phase_next   = PH_STARTER;
                            end
                        end
                        PH_STARTER: begin
                            if (el_inc >= starter_ms_reg) begin
                                relay_next   = 1'b0;
                                elapsed_next = 16'd0;
                                if (in_manual_reg) begin
                                    phase_next = PH_MANUAL;
                                end else begin
                                    from_next  = idle_ang_reg;
                                    to_next    = max_ang_reg;
                                    phase_next = PH_UP;
                                end
                            end
                        end
                        PH_UP: begin
                            wr_next = 1'b1;
                            if (el_inc >= up_ms_reg) begin
                                ang_next     = max_ang_reg;
                                from_next    = max_ang_reg;
                                elapsed_next = 16'd0;
                                phase_next   = PH_DOWN;
                                to_dest_next = 1'b1;
                                mul_go_next  = need_pct;
                                to_next      = (p_sat == PCT_KNEE) ? idle_ang_reg : 8'd0;
                            end else begin
                                div_go_next = 1'b1;
                                div_n_next  = NW'(el_inc) << F;
                                div_d_next  = up_ms_reg;
                                cnt_next    = exp_m1;
                            end
                        end
                        PH_DOWN: begin
                            wr_next = 1'b1;
                            if (el_inc >= down_ms_reg) begin
                                ang_next     = to_reg;
                                phase_next   = PH_MANUAL;
                                running_next = 1'b0;
                            end else begin
                                div_go_next = 1'b1;
                                div_n_next  = NW'(el_inc) << F;
                                div_d_next  = down_ms_reg;
                                cnt_next    = 2'd0;
                            end
                        end
                        PH_MANUAL: begin
                            wr_next     = 1'b1;
                            mul_go_next = need_pct;
                            ang_next    = (p_sat == PCT_KNEE) ? idle_ang_reg : 8'd0;
                        end
                        default: phase_next = PH_IDLE;
                    endcase
                end
            end
            S_PMUL: begin
                if (mul_done) begin
                    // round up toward the exact value on a falling map
                    div_go_next = 1'b1;
                    div_n_next  = NW'(mul_prod) + (pct_down ? NW'(PCT_RND) : '0);
                    div_d_next  = PCT_DEN;
                end
            end
            S_PDIV: begin
                if (div_done) begin
                    if (to_dest_reg) to_next = pct_val;
                    else ang_next = pct_val;
                end
            end
            S_RDIV: begin
                if (div_done) begin
                    q_next      = div_quot[F-1:0];
                    mul_go_next = 1'b1;
                    mul_a_next  = div_quot[F-1:0];
                    mul_b_next  = (cnt_reg == 2'd0) ? MW'(ramp_diff) : MW'(div_quot[F-1:0]);
                end
            end
            S_RPOW: begin
                if (mul_done) begin
                    cnt_next    = cnt_reg - 2'd1;
                    mul_go_next = 1'b1;
                    mul_a_next  = s_new;
                    mul_b_next  = (cnt_reg == 2'd1) ? MW'(ramp_diff) : MW'(q_reg);
                end
            end
            S_RLERP: begin
                if (mul_done) begin
                    ang_next = ramp_down ? from_reg - lerp_delta : from_reg + lerp_delta;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_IDLE;
            elapsed_reg    <= 16'd0;
            running_reg    <= 1'b0;
            relay_reg      <= 1'b0;
            from_reg       <= 8'd0;
            to_reg         <= 8'd0;
            mul_go_reg     <= 1'b0;
            div_go_reg     <= 1'b0;
            mtv_reg        <= 1'b0;
            idle_ang_reg   <= 8'd0;
            max_ang_reg    <= 8'd180;
            starter_ms_reg <= 16'd1000;
            up_ms_reg      <= 16'd1000;
            down_ms_reg    <= 16'd1000;
            exp_reg        <= 3'd3;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            running_reg <= running_next;
            relay_reg   <= relay_next;
            from_reg    <= from_next;
            to_reg      <= to_next;
            mul_go_reg  <= mul_go_next;
            div_go_reg  <= div_go_next;
            if (load_out) mtv_reg <= 1'b1;
            else if (m_tready) mtv_reg <= 1'b0;
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    CFG_IDLE_ANGLE: idle_ang_reg   <= cfg_data[7:0];
                    CFG_MAX_ANGLE:  max_ang_reg    <= cfg_data[7:0];
                    CFG_STARTER_MS: starter_ms_reg <= cfg_data;
                    CFG_RAMP_UP_MS: up_ms_reg      <= cfg_data;
                    CFG_RAMP_DN_MS: down_ms_reg    <= cfg_data;
                    CFG_RAMP_EXP:   exp_reg        <= cfg_data[2:0];
                    default: ;
                endcase
            end
        end
        in_start_reg  <= in_start_next;
        in_stop_reg   <= in_stop_next;
        in_manual_reg <= in_manual_next;
        in_pct_reg    <= in_pct_next;
        wr_reg        <= wr_next;
        ang_reg       <= ang_next;
        to_dest_reg   <= to_dest_next;
        cnt_reg       <= cnt_next;
        q_reg         <= q_next;
        mul_a_reg     <= mul_a_next;
        mul_b_reg     <= mul_b_next;
        div_n_reg     <= div_n_next;
        div_d_reg     <= div_d_next;
        if (load_out) begin
            mtd_reg <= {2'b00, running_reg, phase_reg, relay_reg, ang_reg, wr_reg};
        end
    end

    assign m_tvalid = mtv_reg;
    assign m_tdata  = mtd_reg;

    a_relay_starter: assert property (@(posedge aclk) disable iff (!aresetn)
        relay_reg |-> phase_reg == PH_STARTER)
        else $error("relay on outside starter phase");

    a_running_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        !running_reg |-> (phase_reg == PH_IDLE || phase_reg == PH_MANUAL))
        else $error("sequence phase active while not running");

    a_quiet_angle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> m_tdata[8:1] == 8'd0)
        else $error("angle nonzero without servo write");

    a_one_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_go_reg && div_go_reg))
        else $error("multiplier and divider launched together");

endmodule
